@@ rtl/core/sqoe_pkg.sv @@
// shared types and codes for the stack/queue opcode engine
// no dependencies; imported by the interfaces, the controller and the top level
package sqoe_pkg;

	localparam int DATA_W = 32;
	localparam int DEFAULT_DEPTH = 32;

	localparam logic [2:0] OP_PUSH = 3'd0;
	localparam logic [2:0] OP_DUMP = 3'd1;
	localparam logic [2:0] OP_PEEK = 3'd2;
	localparam logic [2:0] OP_POP  = 3'd3;
	localparam logic [2:0] OP_SWAP = 3'd4;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_EMPTY = 2'd1;
	localparam logic [1:0] ERR_SHORT = 2'd2;
	localparam logic [1:0] ERR_FULL  = 2'd3;

	typedef struct packed {
		logic signed [DATA_W-1:0] data_value;
		logic has_value;
		logic [1:0] error_code;
		logic last_result;
	} result_t;

endpackage

@@ rtl/core/sqoe_req_if.sv @@
// request channel: opcode and push value with valid/ready handshake
// depends on sqoe_pkg
interface sqoe_req_if;
	import sqoe_pkg::*;

	logic valid;
	logic ready;
	logic [2:0] req_type;
	logic signed [DATA_W-1:0] push_value;

	modport source (output valid, output req_type, output push_value, input ready);
	modport sink (input valid, input req_type, input push_value, output ready);
endinterface

@@ rtl/core/sqoe_rsp_if.sv @@
// result channel: one result per transfer with valid/ready handshake
// depends on sqoe_pkg
interface sqoe_rsp_if;
	import sqoe_pkg::*;

	logic valid;
	logic ready;
	logic signed [DATA_W-1:0] data_value;
	logic has_value;
	logic [1:0] error_code;
	logic last_result;

	modport source (output valid, output data_value, output has_value,
		output error_code, output last_result, input ready);
	modport sink (input valid, input data_value, input has_value,
		input error_code, input last_result, output ready);
endinterface

@@ rtl/core/sqoe_ram.sv @@
// generic single write port, single read port ram with registered read data
// no dependencies
module sqoe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ rtl/core/sqoe_ctrl.sv @@
// opcode sequencer: top pointer, element count, ram read-modify-write and result register
// depends on sqoe_pkg, sqoe_req_if, sqoe_rsp_if
module sqoe_ctrl #(
	parameter int DEPTH = sqoe_pkg::DEFAULT_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            queue_mode,
	sqoe_req_if.sink                        req,
	sqoe_rsp_if.source                      rsp,
	output logic                            mem_we,
	output logic [$clog2(DEPTH)-1:0]        mem_waddr,
	output logic [sqoe_pkg::DATA_W-1:0]     mem_wdata,
	output logic [$clog2(DEPTH)-1:0]        mem_raddr,
	input  logic [sqoe_pkg::DATA_W-1:0]     mem_rdata
);
	import sqoe_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_PEEK   = 3'd1;
	localparam logic [2:0] ST_DUMP   = 3'd2;
	localparam logic [2:0] ST_SWAP_A = 3'd3;
	localparam logic [2:0] ST_SWAP_B = 3'd4;
	localparam logic [2:0] ST_SWAP_C = 3'd5;

	logic [2:0] state_q, state_d;
	logic [PW-1:0] top_q, top_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [DATA_W-1:0] tmp_q;
	logic out_valid_q;
	result_t res_q, res_d;
	logic emit;

	logic can_emit, accept, is_empty, is_full, has_two, dump_last;
	logic [PW-1:0] slot1, slot_cnt, top_dec, dump_slot;
	logic [CW-1:0] dump_off, idx_inc;

	// slot of the element that lies off places below the top, circular
	function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] base,
		input logic [CW-1:0] off);
		logic [SW-1:0] sum;
		sum = SW'(base) + SW'(off);
		if (sum >= SW'(DEPTH)) begin
			sum = sum - SW'(DEPTH);
		end
		return sum[PW-1:0];
	endfunction

	assign can_emit  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && can_emit;
	assign accept    = req.valid && req.ready;

	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == CW'(DEPTH));
	assign has_two  = (count_q >= CW'(2));
	assign slot1    = slot_of(top_q, CW'(1));
	assign slot_cnt = slot_of(top_q, count_q);
	assign top_dec  = (top_q == '0) ? PW'(DEPTH - 1) : top_q - PW'(1);

	assign idx_inc   = idx_q + CW'(1);
	assign dump_last = (idx_inc == count_q);
	// read ahead to the next element when the current one leaves this cycle
	assign dump_off  = can_emit ? idx_inc : idx_q;
	assign dump_slot = slot_of(top_q, dump_off);

	always_comb begin
		case (state_q)
			ST_DUMP:   mem_raddr = dump_slot;
			ST_SWAP_A: mem_raddr = slot1;
			default:   mem_raddr = top_q;
		endcase
	end

	always_comb begin
		state_d   = state_q;
		top_d     = top_q;
		count_d   = count_q;
		idx_d     = idx_q;
		emit      = 1'b0;
		res_d     = '0;
		res_d.last_result = 1'b1;
		mem_we    = 1'b0;
		mem_waddr = top_q;
		mem_wdata = req.push_value;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req.req_type)
						OP_PUSH: begin
							emit = 1'b1;
							if (is_full) begin
								res_d.error_code = ERR_FULL;
							end else begin
								mem_we = 1'b1;
								if (queue_mode) begin
									mem_waddr = slot_cnt;
								end else begin
									mem_waddr = top_dec;
									top_d = top_dec;
								end
								count_d = count_q + CW'(1);
							end
						end
						OP_DUMP: begin
							if (is_empty) begin
								emit = 1'b1;
							end else begin
								idx_d = '0;
								state_d = ST_DUMP;
							end
						end
						OP_PEEK: begin
							if (is_empty) begin
								emit = 1'b1;
								res_d.error_code = ERR_EMPTY;
							end else begin
								state_d = ST_PEEK;
							end
						end
						OP_POP: begin
							emit = 1'b1;
							if (is_empty) begin
								res_d.error_code = ERR_EMPTY;
							end else begin
								top_d = slot1;
								count_d = count_q - CW'(1);
							end
						end
						OP_SWAP: begin
							if (has_two) begin
								state_d = ST_SWAP_A;
							end else begin
								emit = 1'b1;
								res_d.error_code = ERR_SHORT;
							end
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			ST_PEEK: begin
				if (can_emit) begin
					emit = 1'b1;
					res_d.data_value = mem_rdata;
					res_d.has_value = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_DUMP: begin
				if (can_emit) begin
					emit = 1'b1;
					res_d.data_value = mem_rdata;
					res_d.has_value = 1'b1;
					res_d.last_result = dump_last;
					idx_d = idx_inc;
					if (dump_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_SWAP_A: begin
				state_d = ST_SWAP_B;
			end
			ST_SWAP_B: begin
				// second element lands on the top slot
				mem_we = 1'b1;
				mem_waddr = top_q;
				mem_wdata = mem_rdata;
				state_d = ST_SWAP_C;
			end
			ST_SWAP_C: begin
				if (can_emit) begin
					mem_we = 1'b1;
					mem_waddr = slot1;
					mem_wdata = tmp_q;
					emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			top_q <= '0;
			count_q <= '0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			top_q <= top_d;
			count_q <= count_d;
			idx_q <= idx_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res_d;
		end
		// old top element is held while the second one is read
		if (state_q == ST_SWAP_A) begin
			tmp_q <= mem_rdata;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.data_value  = res_q.data_value;
	assign rsp.has_value   = res_q.has_value;
	assign rsp.error_code  = res_q.error_code;
	assign rsp.last_result = res_q.last_result;
endmodule

@@ rtl/core/stack_queue_opcode_engine.sv @@
// Stack/queue opcode engine (top level): mode register, element ram and sequencer.
// Runs push, pop, peek, swap and dump opcodes on up to DEPTH signed values.
// Depends on sqoe_pkg, sqoe_req_if, sqoe_rsp_if, sqoe_ram, sqoe_ctrl.
//
// req carries one opcode per transfer (req_type, push_value); rsp returns results,
// one per transfer, last_result marking the final result of an opcode.
// cfg_we/cfg_wdata write queue_mode: 0 pushes at the top, 1 appends at the bottom.
// Elements live in a single-port-write, registered-read ram used as a circular
// buffer around the top pointer.
// Push, pop, unused codes, dump of an empty store and every opcode answered
// with an error code finish in the transfer cycle; peek adds a ram read; swap
// steps through read top, read second, write top, write second (single write
// port); dump streams its elements, one ram read per cycle unless the receiver stalls.
// The result register loads in the last cycle of an opcode: the transfer cycle
// for push, pop, unused codes and errors, after the ram read for peek and for
// each dump element, and with the second write for swap. A new opcode is taken
// once the previous one is done and the result register is free or drained.
// Reset empties the store and sets stack mode; ram contents are not cleared.
// A stalled receiver holds the result register; the sequencer waits in the
// state that produces the next result.
module stack_queue_opcode_engine #(
	parameter int DEPTH = sqoe_pkg::DEFAULT_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	sqoe_req_if.sink   req,
	sqoe_rsp_if.source rsp,
	input  logic cfg_we,
	input  logic cfg_wdata
);
	import sqoe_pkg::*;

	localparam int PW = $clog2(DEPTH);

	logic queue_mode_q;
	logic mem_we;
	logic [PW-1:0] mem_waddr, mem_raddr;
	logic [DATA_W-1:0] mem_wdata, mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_mode_q <= 1'b0;
		end else if (cfg_we) begin
			queue_mode_q <= cfg_wdata;
		end
	end

	sqoe_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	sqoe_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.queue_mode (queue_mode_q),
		.req        (req),
		.rsp        (rsp),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);
endmodule

@@ tb/stack_queue_opcode_engine_tb.sv @@
`timescale 1ns / 1ps
// self-checking bench for stack_queue_opcode_engine: directed table, full-store sweep, random phases
// results are checked against table values or a behavioral mirror of the element store;
// needs sqoe_pkg, sqoe_req_if, sqoe_rsp_if and the engine rtl
module stack_queue_opcode_engine_tb;
	import sqoe_pkg::*;

	localparam int DEPTH = DEFAULT_DEPTH;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_LAST = 3'd7;

	typedef struct {
		bit mode;
		logic [2:0] op;
		logic signed [DATA_W-1:0] value;
		bit typed;
		result_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;

	sqoe_req_if req_ch();
	sqoe_rsp_if rsp_ch();

	stack_queue_opcode_engine #(.DEPTH(DEPTH)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// mirror of the engine state
	logic signed [DATA_W-1:0] mirror_elems [DEPTH];
	int unsigned mirror_top = 0;
	int unsigned mirror_count = 0;
	bit mirror_qmode = 1'b0;

	result_t pending_results[$];
	stim_row_t stim_table[$];
	int send_gap_pct = 12;
	int recv_stall_pct = 63;
	int stall_left = 0;
	int fail_count = 0;
	int cycle_count = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL stack_queue_opcode_engine");
			$finish;
		end
	end

	// runs one opcode on the mirror and appends the results it causes
	function automatic void apply_opcode(input logic [2:0] op,
			input logic signed [DATA_W-1:0] val, ref result_t outs[$]);
		result_t r;
		int unsigned i;
		int unsigned second;
		logic signed [DATA_W-1:0] t;
		r = '0;
		r.last_result = 1'b1;
		case (op)
			OP_PUSH: begin
				if (mirror_count >= DEPTH) begin
					r.error_code = ERR_FULL;
				end else begin
					if (mirror_qmode) begin
						mirror_elems[(mirror_top + mirror_count) % DEPTH] = val;
					end else begin
						mirror_top = (mirror_top + DEPTH - 1) % DEPTH;
						mirror_elems[mirror_top] = val;
					end
					mirror_count++;
				end
				outs.push_back(r);
			end
			OP_DUMP: begin
				if (mirror_count == 0)
					outs.push_back(r);
				for (i = 0; i < mirror_count; i++) begin
					r.data_value = mirror_elems[(mirror_top + i) % DEPTH];
					r.has_value = 1'b1;
					r.last_result = (i + 1 == mirror_count);
					outs.push_back(r);
				end
			end
			OP_PEEK: begin
				if (mirror_count == 0) begin
					r.error_code = ERR_EMPTY;
				end else begin
					r.data_value = mirror_elems[mirror_top];
					r.has_value = 1'b1;
				end
				outs.push_back(r);
			end
			OP_POP: begin
				if (mirror_count == 0) begin
					r.error_code = ERR_EMPTY;
				end else begin
					mirror_top = (mirror_top + 1) % DEPTH;
					mirror_count--;
				end
				outs.push_back(r);
			end
			OP_SWAP: begin
				if (mirror_count < 2) begin
					r.error_code = ERR_SHORT;
				end else begin
					second = (mirror_top + 1) % DEPTH;
					t = mirror_elems[mirror_top];
					mirror_elems[mirror_top] = mirror_elems[second];
					mirror_elems[second] = t;
				end
				outs.push_back(r);
			end
			default: begin
				outs.push_back(r);
			end
		endcase
	endfunction

	function automatic void check_result();
		result_t want;
		if (pending_results.size() == 0) begin
			$display("%0t: unexpected result data_value %0d has_value %0b error_code %0d last %0b",
				$time, rsp_ch.data_value, rsp_ch.has_value, rsp_ch.error_code,
				rsp_ch.last_result);
			fail_count++;
			return;
		end
		want = pending_results.pop_front();
		if (rsp_ch.data_value !== want.data_value) begin
			$display("%0t: data_value expected %0d got %0d", $time, want.data_value,
				rsp_ch.data_value);
			fail_count++;
		end
		if (rsp_ch.has_value !== want.has_value) begin
			$display("%0t: has_value expected %0b got %0b", $time, want.has_value,
				rsp_ch.has_value);
			fail_count++;
		end
		if (rsp_ch.error_code !== want.error_code) begin
			$display("%0t: error_code expected %0d got %0d", $time, want.error_code,
				rsp_ch.error_code);
			fail_count++;
		end
		if (rsp_ch.last_result !== want.last_result) begin
			$display("%0t: last_result expected %0b got %0b", $time, want.last_result,
				rsp_ch.last_result);
			fail_count++;
		end
	endfunction

	// result side: check each transfer, then pick ready for the next edge
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			check_result();
		if (stall_left > 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_item(input logic [2:0] op, input logic signed [DATA_W-1:0] val,
			input bit typed, input result_t want);
		result_t outs[$];
		if ($urandom_range(99) < send_gap_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_gap_pct) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= op;
		req_ch.push_value <= val;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		// transfer taken at this edge
		apply_opcode(op, val, outs);
		if (typed)
			pending_results.push_back(want);
		else
			foreach (outs[k]) pending_results.push_back(outs[k]);
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_mode(input bit m);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		mirror_qmode = m;
	endtask

	function automatic stim_row_t mk_row(input bit mode, input logic [2:0] op,
			input logic signed [DATA_W-1:0] value, input bit typed,
			input logic signed [DATA_W-1:0] data, input bit has, input logic [1:0] err);
		stim_row_t r;
		r.mode = mode;
		r.op = op;
		r.value = value;
		r.typed = typed;
		r.want.data_value = data;
		r.want.has_value = has;
		r.want.error_code = err;
		r.want.last_result = 1'b1;
		return r;
	endfunction

	function automatic logic [2:0] pick_op(input bit filling);
		int r;
		r = $urandom_range(99);
		if (r < 3)
			return 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
		if (filling) begin
			if (r < 58) return OP_PUSH;
			if (r < 70) return OP_POP;
			if (r < 80) return OP_PEEK;
			if (r < 90) return OP_SWAP;
			return OP_DUMP;
		end
		if (r < 23) return OP_PUSH;
		if (r < 58) return OP_POP;
		if (r < 73) return OP_PEEK;
		if (r < 88) return OP_SWAP;
		return OP_DUMP;
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(7))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	task automatic run_random(input int n);
		int done_items;
		bit filling;
		logic [2:0] op;
		done_items = 0;
		filling = 1'b1;
		while (done_items < n) begin
			op = pick_op(filling);
			send_item(op, pick_value(), 1'b0, '0);
			if (op <= OP_SWAP) begin
				done_items++;
				if (done_items % 4 == 0)
					filling = !filling;
				// long result stall while requests keep coming
				if (done_items == 2)
					stall_left = 300;
				if (done_items == n / 2)
					wait_drained();
			end
		end
	endtask

	initial begin
		stim_row_t full_row;

		req_ch.valid = 1'b0;
		req_ch.req_type = OP_PUSH;
		req_ch.push_value = '0;
		rsp_ch.ready = 1'b0;

		stim_table.push_back(mk_row(0, OP_PEEK, 0, 1, 0, 0, ERR_EMPTY));
		stim_table.push_back(mk_row(0, OP_POP, 0, 1, 0, 0, ERR_EMPTY));
		stim_table.push_back(mk_row(0, OP_SWAP, 0, 1, 0, 0, ERR_SHORT));
		stim_table.push_back(mk_row(0, OP_DUMP, 0, 1, 0, 0, ERR_NONE));
		stim_table.push_back(mk_row(0, OP_PUSH, 32'sh7fff_ffff, 1, 0, 0, ERR_NONE));
		stim_table.push_back(mk_row(0, OP_SWAP, 0, 1, 0, 0, ERR_SHORT));
		stim_table.push_back(mk_row(0, OP_PUSH, 32'sh8000_0000, 1, 0, 0, ERR_NONE));
		stim_table.push_back(mk_row(0, OP_PEEK, 0, 1, 32'sh8000_0000, 1, ERR_NONE));
		stim_table.push_back(mk_row(0, OP_SWAP, 0, 1, 0, 0, ERR_NONE));
		stim_table.push_back(mk_row(0, OP_PEEK, 0, 1, 32'sh7fff_ffff, 1, ERR_NONE));
		stim_table.push_back(mk_row(0, OP_DUMP, 0, 0, 0, 0, ERR_NONE));
		stim_table.push_back(mk_row(0, OP_SPARE_FIRST, 32'sh1234_5678, 1, 0, 0, ERR_NONE));
		stim_table.push_back(mk_row(0, OP_SPARE_FIRST + 3'd1, 0, 1, 0, 0, ERR_NONE));
		stim_table.push_back(mk_row(0, OP_SPARE_LAST, -32'sd1, 1, 0, 0, ERR_NONE));
		stim_table.push_back(mk_row(0, OP_POP, 0, 1, 0, 0, ERR_NONE));
		stim_table.push_back(mk_row(0, OP_POP, 0, 1, 0, 0, ERR_NONE));
		stim_table.push_back(mk_row(0, OP_POP, 0, 1, 0, 0, ERR_EMPTY));
		stim_table.push_back(mk_row(1, OP_PUSH, 32'sd1, 1, 0, 0, ERR_NONE));
		stim_table.push_back(mk_row(1, OP_PUSH, 32'sd2, 1, 0, 0, ERR_NONE));
		stim_table.push_back(mk_row(1, OP_PUSH, -32'sd1, 1, 0, 0, ERR_NONE));
		stim_table.push_back(mk_row(1, OP_PEEK, 0, 1, 32'sd1, 1, ERR_NONE));
		stim_table.push_back(mk_row(1, OP_SWAP, 0, 0, 0, 0, ERR_NONE));
		stim_table.push_back(mk_row(1, OP_DUMP, 0, 0, 0, 0, ERR_NONE));
		stim_table.push_back(mk_row(0, OP_PUSH, 0, 0, 0, 0, ERR_NONE));
		stim_table.push_back(mk_row(0, OP_DUMP, 0, 0, 0, 0, ERR_NONE));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[k]) begin
			if (stim_table[k].mode != mirror_qmode)
				write_mode(stim_table[k].mode);
			send_item(stim_table[k].op, stim_table[k].value, stim_table[k].typed,
				stim_table[k].want);
		end

		// fill to the limit, overflow once, dump, swap and peek the full store, then empty it
		while (mirror_count < DEPTH)
			send_item(OP_PUSH, pick_value(), 1'b0, '0);
		full_row = mk_row(0, OP_PUSH, 0, 1, 0, 0, ERR_FULL);
		send_item(OP_PUSH, pick_value(), 1'b1, full_row.want);
		send_item(OP_DUMP, 0, 1'b0, '0);
		send_item(OP_SWAP, 0, 1'b0, '0);
		send_item(OP_PEEK, 0, 1'b0, '0);
		while (mirror_count != 0)
			send_item(OP_POP, 0, 1'b0, '0);

		write_mode(1'b1);
		run_random(8);

		write_mode(1'b0);
		send_gap_pct = 63;
		recv_stall_pct = 12;
		run_random(8);

		write_mode(1'b1);
		send_gap_pct = 0;
		recv_stall_pct = 0;
		run_random(8);

		wait_drained();
		repeat (40) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("PASS stack_queue_opcode_engine");
		end else begin
			$display("FAIL stack_queue_opcode_engine");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/sqoe_pkg.sv
rtl/core/sqoe_req_if.sv
rtl/core/sqoe_rsp_if.sv
rtl/core/sqoe_ram.sv
rtl/core/sqoe_ctrl.sv
rtl/core/stack_queue_opcode_engine.sv
tb/stack_queue_opcode_engine_tb.sv
